FILE: rtl/core/owtr_pkg.sv
// ============================================================================
// owtr_pkg
// Shared types and constants for the single-wire temperature reader.
// ============================================================================
package owtr_pkg;

    // Width of the conversion wait register; the other timing registers are 16 bits.
    localparam int unsigned CONV_W  = 24;
    localparam int unsigned SHORT_W = 16;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_RESET_LOW    = 3'd0;
    localparam logic [2:0] REG_RESET_WAIT   = 3'd1;
    localparam logic [2:0] REG_WRITE_LOW    = 3'd2;
    localparam logic [2:0] REG_WRITE_BIT    = 3'd3;
    localparam logic [2:0] REG_READ_LOW     = 3'd4;
    localparam logic [2:0] REG_READ_SAMPLE  = 3'd5;
    localparam logic [2:0] REG_READ_RECOVER = 3'd6;
    localparam logic [2:0] REG_CONVERT_WAIT = 3'd7;

    // Register reset values.
    localparam logic [SHORT_W-1:0] RST_RESET_LOW    = 16'd18000;
    localparam logic [SHORT_W-1:0] RST_RESET_WAIT   = 16'd12000;
    localparam logic [SHORT_W-1:0] RST_WRITE_LOW    = 16'd360;
    localparam logic [SHORT_W-1:0] RST_WRITE_BIT    = 16'd1080;
    localparam logic [SHORT_W-1:0] RST_READ_LOW     = 16'd144;
    localparam logic [SHORT_W-1:0] RST_READ_SAMPLE  = 16'd96;
    localparam logic [SHORT_W-1:0] RST_READ_RECOVER = 16'd720;
    localparam logic [CONV_W-1:0]  RST_CONVERT_WAIT = 24'hFFFFFF;

    // Bus command bytes.
    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_CONVERT   = 8'h44;
    localparam logic [7:0] CMD_READ_PAD  = 8'hBE;
    localparam logic [7:0] CMD_NONE      = 8'h00;

    // Steps of the sequence.
    localparam logic [2:0] STEP_SKIP_A   = 3'd0;
    localparam logic [2:0] STEP_CONVERT  = 3'd1;
    localparam logic [2:0] STEP_CONV_WAIT = 3'd2;
    localparam logic [2:0] STEP_SKIP_B   = 3'd3;
    localparam logic [2:0] STEP_READ_CMD = 3'd4;
    localparam logic [2:0] STEP_READ_LO  = 3'd5;
    localparam logic [2:0] STEP_READ_HI  = 3'd6;

    typedef struct packed {
        logic start_req;
        logic line_in;
    } t_in_item;

    typedef struct packed {
        logic        line_drive_low;
        logic        busy_res;
        logic        done_res;
        logic [15:0] raw_temp;
    } t_out_item;

    // Command byte sent during a write step.
    function automatic logic [7:0] step_cmd(input logic [2:0] step);
        logic [7:0] cmd;
        case (step)
            STEP_SKIP_A:   cmd = CMD_SKIP_ROM;
            STEP_CONVERT:  cmd = CMD_CONVERT;
            STEP_SKIP_B:   cmd = CMD_SKIP_ROM;
            STEP_READ_CMD: cmd = CMD_READ_PAD;
            default:       cmd = CMD_NONE;
        endcase
        return cmd;
    endfunction

endpackage

FILE: rtl/core/one_wire_temperature_reader_top.sv
// ============================================================================
// one_wire_temperature_reader_top
// Single-wire bus master that runs a full temperature read of one sensor.
// ============================================================================
// Each input word is one bus tick carrying a start request and the sampled
// line level; each accepted word yields exactly one registered result word;
// and a new word can be taken every cycle (the input is stalled only
// while a finished result waits downstream). A start in idle runs: reset
// pulse, skip ROM, convert, conversion wait, reset pulse, skip ROM, read
// scratchpad, then two bytes read LSB first. The result word holds the line
// drive level, busy, a one-tick done flag and the last raw 16-bit reading in
// 1/16 degree units. All bus timing is counted in ticks from the APB
// registers; each interval lasts at least one tick, and every interval length is
// clamped to the TIMER_WIDTH-bit tick counter. No presence pulse is checked.
module one_wire_temperature_reader_top
    import owtr_pkg::*;
#(
    parameter int unsigned TIMER_WIDTH = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_in_item          i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output t_out_item         o_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int unsigned LIM_W = ((TIMER_WIDTH > CONV_W) ? TIMER_WIDTH : CONV_W) + 1;
    localparam logic [LIM_W-1:0] TIMER_MAX =
        LIM_W'((64'd1 << TIMER_WIDTH) - 64'd1);

    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_RST_LOW    = 4'd1;
    localparam logic [3:0] PH_RST_WAIT   = 4'd2;
    localparam logic [3:0] PH_WR_LOW     = 4'd3;
    localparam logic [3:0] PH_WR_BIT     = 4'd4;
    localparam logic [3:0] PH_RD_LOW     = 4'd5;
    localparam logic [3:0] PH_RD_SAMPLE  = 4'd6;
    localparam logic [3:0] PH_RD_RECOVER = 4'd7;
    localparam logic [3:0] PH_CONV       = 4'd8;
    localparam logic [3:0] PH_DONE       = 4'd9;

    // Configuration registers.
    logic [SHORT_W-1:0] r_reset_low, r_reset_wait, r_write_low, r_write_bit;
    logic [SHORT_W-1:0] r_read_low, r_read_sample, r_read_recover;
    logic [CONV_W-1:0]  r_convert_wait;

    // Sequencer state.
    logic [3:0]             r_phase, n_phase;
    logic [TIMER_WIDTH-1:0] r_tick, n_tick;
    logic [2:0]             r_bit, n_bit;
    logic [2:0]             r_step, n_step;
    logic [7:0]             r_shift, n_shift;
    logic [7:0]             r_low_byte, n_low_byte;
    logic [15:0]            r_reading, n_reading;

    // Result register.
    logic      r_out_valid;
    t_out_item r_out, n_out;

    logic              w_accept;
    logic              w_cfg_wr;
    logic [2:0]        w_cfg_idx;
    logic [CONV_W-1:0] w_interval;
    logic [LIM_W-1:0]  w_lim;
    logic [LIM_W-1:0]  w_tick_next;
    logic              w_end;
    logic              w_cur_bit;
    logic [7:0]        w_cmd;

    function automatic logic [3:0] step_phase(input logic [2:0] step);
        logic [3:0] ph;
        if (step == STEP_CONV_WAIT) begin
            ph = PH_CONV;
        end else if (step == STEP_READ_LO || step == STEP_READ_HI) begin
            ph = PH_RD_LOW;
        end else begin
            ph = PH_WR_LOW;
        end
        return ph;
    endfunction

    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // ------------------------------------------------------------------
    // APB register file
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign w_cfg_idx = paddr[4:2];
    assign w_cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reset_low    <= RST_RESET_LOW;
            r_reset_wait   <= RST_RESET_WAIT;
            r_write_low    <= RST_WRITE_LOW;
            r_write_bit    <= RST_WRITE_BIT;
            r_read_low     <= RST_READ_LOW;
            r_read_sample  <= RST_READ_SAMPLE;
            r_read_recover <= RST_READ_RECOVER;
            r_convert_wait <= RST_CONVERT_WAIT;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_RESET_LOW:    r_reset_low    <= pwdata[SHORT_W-1:0];
                REG_RESET_WAIT:   r_reset_wait   <= pwdata[SHORT_W-1:0];
                REG_WRITE_LOW:    r_write_low    <= pwdata[SHORT_W-1:0];
                REG_WRITE_BIT:    r_write_bit    <= pwdata[SHORT_W-1:0];
                REG_READ_LOW:     r_read_low     <= pwdata[SHORT_W-1:0];
                REG_READ_SAMPLE:  r_read_sample  <= pwdata[SHORT_W-1:0];
                REG_READ_RECOVER: r_read_recover <= pwdata[SHORT_W-1:0];
                REG_CONVERT_WAIT: r_convert_wait <= pwdata[CONV_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (w_cfg_idx)
            REG_RESET_LOW:    prdata = DATA_W'(r_reset_low);
            REG_RESET_WAIT:   prdata = DATA_W'(r_reset_wait);
            REG_WRITE_LOW:    prdata = DATA_W'(r_write_low);
            REG_WRITE_BIT:    prdata = DATA_W'(r_write_bit);
            REG_READ_LOW:     prdata = DATA_W'(r_read_low);
            REG_READ_SAMPLE:  prdata = DATA_W'(r_read_sample);
            REG_READ_RECOVER: prdata = DATA_W'(r_read_recover);
            REG_CONVERT_WAIT: prdata = DATA_W'(r_convert_wait);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Interval timer: one shared compare against the current phase length
    // ------------------------------------------------------------------
    always_comb begin
        unique case (r_phase)
            PH_RST_LOW:    w_interval = CONV_W'(r_reset_low);
            PH_RST_WAIT:   w_interval = CONV_W'(r_reset_wait);
            PH_WR_LOW:     w_interval = CONV_W'(r_write_low);
            PH_WR_BIT:     w_interval = CONV_W'(r_write_bit);
            PH_RD_LOW:     w_interval = CONV_W'(r_read_low);
            PH_RD_SAMPLE:  w_interval = CONV_W'(r_read_sample);
            PH_RD_RECOVER: w_interval = CONV_W'(r_read_recover);
            PH_CONV:       w_interval = r_convert_wait;
            default:       w_interval = '0;
        endcase
    end

    // A zero or one length both end the interval on its first tick.
    assign w_lim       = (LIM_W'(w_interval) > TIMER_MAX) ? TIMER_MAX : LIM_W'(w_interval);
    assign w_tick_next = LIM_W'(r_tick) + LIM_W'(1);
    assign w_end       = (w_tick_next >= w_lim);
    assign w_cmd       = step_cmd(r_step);
    assign w_cur_bit   = w_cmd[r_bit];

    // ------------------------------------------------------------------
    // Sequencer next state and result
    // ------------------------------------------------------------------
    always_comb begin
        n_phase    = r_phase;
        n_tick     = r_tick;
        n_bit      = r_bit;
        n_step     = r_step;
        n_shift    = r_shift;
        n_low_byte = r_low_byte;
        n_reading  = r_reading;

        n_out.line_drive_low = 1'b0;
        n_out.busy_res       = 1'b1;
        n_out.done_res       = 1'b0;

        // Timed phases advance the tick counter unless the interval ends.
        if (w_end) begin
            n_tick = '0;
        end else begin
            n_tick = w_tick_next[TIMER_WIDTH-1:0];
        end

        unique case (r_phase)
            PH_RST_LOW: begin
                n_out.line_drive_low = 1'b1;
                if (w_end) begin
                    n_phase = PH_RST_WAIT;
                end
            end
            PH_RST_WAIT: begin
                if (w_end) begin
                    n_bit   = '0;
                    n_phase = step_phase(r_step);
                end
            end
            PH_WR_LOW: begin
                n_out.line_drive_low = 1'b1;
                if (w_end) begin
                    n_phase = PH_WR_BIT;
                end
            end
            PH_WR_BIT: begin
                n_out.line_drive_low = ~w_cur_bit;
                if (w_end) begin
                    if (r_bit == 3'd7) begin
                        n_step  = r_step + 3'd1;
                        n_bit   = '0;
                        n_phase = step_phase(r_step + 3'd1);
                    end else begin
                        n_bit   = r_bit + 3'd1;
                        n_phase = PH_WR_LOW;
                    end
                end
            end
            PH_RD_LOW: begin
                n_out.line_drive_low = 1'b1;
                if (w_end) begin
                    n_phase = PH_RD_SAMPLE;
                end
            end
            PH_RD_SAMPLE: begin
                if (w_end) begin
                    n_shift = {i_data.line_in, r_shift[7:1]};
                    n_phase = PH_RD_RECOVER;
                end
            end
            PH_RD_RECOVER: begin
                if (w_end) begin
                    if (r_bit != 3'd7) begin
                        n_bit   = r_bit + 3'd1;
                        n_phase = PH_RD_LOW;
                    end else if (r_step == STEP_READ_LO) begin
                        n_low_byte = r_shift;
                        n_step     = STEP_READ_HI;
                        n_bit      = '0;
                        n_phase    = PH_RD_LOW;
                    end else begin
                        n_reading = {r_shift, r_low_byte};
                        n_bit     = '0;
                        n_phase   = PH_DONE;
                    end
                end
            end
            PH_CONV: begin
                if (w_end) begin
                    n_step  = STEP_SKIP_B;
                    n_bit   = '0;
                    n_phase = PH_RST_LOW;
                end
            end
            PH_DONE: begin
                n_out.busy_res = 1'b0;
                n_out.done_res = 1'b1;
                n_tick         = r_tick;
                n_phase        = PH_IDLE;
            end
            default: begin
                // Idle and any unused phase code.
                n_out.busy_res = 1'b0;
                n_tick         = r_tick;
                n_phase        = PH_IDLE;
                if (i_data.start_req) begin
                    n_step  = STEP_SKIP_A;
                    n_bit   = '0;
                    n_tick  = '0;
                    n_shift = '0;
                    n_phase = PH_RST_LOW;
                end
            end
        endcase

        n_out.raw_temp = n_reading;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_step      <= '0;
            r_shift     <= '0;
            r_low_byte  <= '0;
            r_reading   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_phase     <= n_phase;
                r_tick      <= n_tick;
                r_bit       <= n_bit;
                r_step      <= n_step;
                r_shift     <= n_shift;
                r_low_byte  <= n_low_byte;
                r_reading   <= n_reading;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.done_res && r_out.busy_res))
        else $error("done and busy reported together");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_phase == PH_DONE) |=> (r_phase == PH_IDLE))
        else $error("done phase did not return to idle");

    a_read_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RD_LOW || r_phase == PH_RD_SAMPLE || r_phase == PH_RD_RECOVER)
        |-> (r_step == STEP_READ_LO || r_step == STEP_READ_HI))
        else $error("read slot outside a read step");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_phase) && $stable(r_reading))
        else $error("sequencer moved without an accepted word");

    a_reading_at_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_phase != PH_RD_RECOVER) |=> $stable(r_reading))
        else $error("reading changed outside the last read recovery");

endmodule
